@@ design/olrw_pkg.sv @@
// Package for the offset/limit row window unit.
// Holds item kind and result status codes, register indexes and the result control struct.
// No dependencies; the top, core and skid design files import it.
package olrw_pkg;

  // Item kinds on the input channel
  typedef enum logic [1:0] {
    KIND_CHUNK   = 2'd0,
    KIND_EOS     = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_DELIVER  = 2'd0,
    STATUS_DEPLETED = 2'd1,
    STATUS_LIMIT    = 2'd2
  } status_e;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SKIP_ROWS = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_LIMIT = 1'd1;

  // Control part of one result leaving the window core
  typedef struct packed {
    logic    push;
    status_e status;
  } res_ctl_t;

endpackage

@@ design/olrw_if.sv @@
// Channel interfaces for the offset/limit row window unit.
// olrw_in_if carries chunk items, olrw_out_if carries results; both valid/ready.
// Depends on nothing but the ROW_BITS parameter.
interface olrw_in_if #(
  parameter int unsigned ROW_BITS = 24
);
  logic                valid;
  logic                ready;
  logic [1:0]          kind;
  logic [ROW_BITS-1:0] chunk_rows;
  logic                has_table;

  modport source (output valid, kind, chunk_rows, has_table, input ready);
  modport sink   (input valid, kind, chunk_rows, has_table, output ready);
endinterface

interface olrw_out_if #(
  parameter int unsigned ROW_BITS = 24
);
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [ROW_BITS-1:0] rows_skipped;
  logic [ROW_BITS-1:0] rows_out;

  modport source (output valid, status, rows_skipped, rows_out, input ready);
  modport sink   (input valid, status, rows_skipped, rows_out, output ready);
endinterface

@@ design/offset_limit_row_window.sv @@
// Offset/limit row window unit: skips leading rows and clips chunks to a row budget.
// A result passes from the core through the output register, or the skid stage while the output stalls.
// Throughput: one item per cycle while input ready is high; the skip and budget counters update in that cycle.
// The skid stage holds one result while the output stalls, then input ready drops.
// Reset (asynchronous, active low) clears both registers, the counters and the finished flag.
module offset_limit_row_window_unit import olrw_pkg::*; #(
  parameter int unsigned ROW_BITS = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [ROW_BITS-1:0]     cfg_data_i,
  olrw_in_if.sink                 item_i,
  olrw_out_if.source              result_o
);

  localparam int unsigned DATA_W = 2 + 2 * ROW_BITS;

  res_ctl_t            res_ctl;
  logic [ROW_BITS-1:0] res_skipped, res_rows;
  logic                acc;
  logic                in_ready;
  logic [DATA_W-1:0]   res_data, out_data;

  assign acc          = item_i.valid && in_ready;
  assign item_i.ready = in_ready;

  olrw_core #(
    .ROW_BITS (ROW_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .acc_i         (acc),
    .kind_i        (item_i.kind),
    .rows_i        (item_i.chunk_rows),
    .has_table_i   (item_i.has_table),
    .res_ctl_o     (res_ctl),
    .res_skipped_o (res_skipped),
    .res_rows_o    (res_rows)
  );

  assign res_data = {res_ctl.status, res_skipped, res_rows};

  olrw_skid #(
    .DATA_W (DATA_W)
  ) u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_ctl.push),
    .data_i  (res_data),
    .ready_o (in_ready),
    .valid_o (result_o.valid),
    .data_o  (out_data),
    .ready_i (result_o.ready)
  );

  assign result_o.status       = out_data[DATA_W-1 -: 2];
  assign result_o.rows_skipped = out_data[2*ROW_BITS-1 -: ROW_BITS];
  assign result_o.rows_out     = out_data[ROW_BITS-1:0];

  // A restart or an unused kind never produces a result
  a_restart_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (item_i.kind == KIND_RESTART || item_i.kind == KIND_UNUSED) |-> !res_ctl.push)
    else $error("result pushed for restart or unused kind");

  // A result is only pushed for an accepted item
  a_push_needs_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_ctl.push |-> acc)
    else $error("result pushed without an input transfer");

  // Input ready low means a result is waiting at the output
  a_backpressure_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> result_o.valid)
    else $error("input stalled with no pending result");

  // After a pushed result the output valid is high in the next cycle
  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_ctl.push |=> result_o.valid)
    else $error("pushed result not visible");

endmodule

@@ design/olrw_core.sv @@
// Window core: configuration registers, skip/budget counters and the per-item decision.
// Updates its state on every accepted item and emits at most one result in the same cycle.
// Depends on olrw_pkg.
module olrw_core import olrw_pkg::*; #(
  parameter int unsigned ROW_BITS = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [ROW_BITS-1:0]     cfg_data_i,
  input  logic                    acc_i,
  input  logic [1:0]              kind_i,
  input  logic [ROW_BITS-1:0]     rows_i,
  input  logic                    has_table_i,
  output res_ctl_t                res_ctl_o,
  output logic [ROW_BITS-1:0]     res_skipped_o,
  output logic [ROW_BITS-1:0]     res_rows_o
);

  logic [ROW_BITS-1:0] skip_rows_q, row_limit_q;
  logic [ROW_BITS-1:0] skip_left_q, skip_left_d;
  logic [ROW_BITS-1:0] budget_q, budget_d;
  logic                finished_q, finished_d;
  logic                limit_on_q, limit_on_d;

  // Configuration writes; they only matter at the next restart
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_rows_q <= '0;
      row_limit_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_SKIP_ROWS) begin
        skip_rows_q <= cfg_data_i;
      end else if (cfg_idx_i == CFG_ROW_LIMIT) begin
        row_limit_q <= cfg_data_i;
      end
    end
  end

  // Decide skip, clip and result for the transfer at hand
  always_comb begin
    logic [ROW_BITS-1:0] rem;
    logic                fully_skipped;
    logic                stop;
    skip_left_d          = skip_left_q;
    budget_d             = budget_q;
    finished_d           = finished_q;
    limit_on_d           = limit_on_q;
    res_ctl_o.push       = 1'b0;
    res_ctl_o.status     = STATUS_DELIVER;
    res_skipped_o        = '0;
    res_rows_o           = '0;
    rem                  = rows_i;
    fully_skipped        = 1'b0;
    stop                 = 1'b0;
    if (acc_i) begin
      case (kind_i)
        KIND_RESTART: begin
          skip_left_d = skip_rows_q;
          budget_d    = row_limit_q;
          limit_on_d  = (row_limit_q != '0);
          finished_d  = 1'b0;
        end
        KIND_EOS: begin
          if (!finished_q) begin
            finished_d       = 1'b1;
            res_ctl_o.push   = 1'b1;
            res_ctl_o.status = STATUS_DEPLETED;
          end
        end
        KIND_CHUNK: begin
          if (!finished_q) begin
            if (!has_table_i && rows_i == '0) begin
              // tableless empty chunk passes untouched
              res_ctl_o.push = 1'b1;
            end else if (skip_left_q == '0 && !limit_on_q) begin
              // open window: pass whole, empty chunk ends the stream
              if (rows_i != '0) begin
                res_ctl_o.push = 1'b1;
                res_rows_o     = rows_i;
              end else begin
                finished_d       = 1'b1;
                res_ctl_o.push   = 1'b1;
                res_ctl_o.status = STATUS_DEPLETED;
              end
            end else begin
              // drop leading rows
              if (skip_left_q != '0) begin
                if (skip_left_q > rows_i) begin
                  skip_left_d   = skip_left_q - rows_i;
                  fully_skipped = 1'b1;
                end else begin
                  res_skipped_o = skip_left_q;
                  rem           = rows_i - skip_left_q;
                  skip_left_d   = '0;
                end
              end
              // clip to the budget
              if (!fully_skipped) begin
                if (budget_q != '0) begin
                  if (budget_q > rem) begin
                    budget_d = budget_q - rem;
                  end else begin
                    rem      = budget_q;
                    budget_d = '0;
                  end
                end else if (limit_on_q) begin
                  stop             = 1'b1;
                  finished_d       = 1'b1;
                  res_ctl_o.push   = 1'b1;
                  res_ctl_o.status = STATUS_LIMIT;
                  res_skipped_o    = '0;
                end
                if (!stop && rem != '0) begin
                  res_ctl_o.push = 1'b1;
                  res_rows_o     = rem;
                end
              end
              if (!res_ctl_o.push) begin
                res_skipped_o = '0;
              end
            end
          end
        end
        default: begin
          // unused kind: ignore
        end
      endcase
    end
  end

  // Window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_left_q <= '0;
      budget_q    <= '0;
      finished_q  <= 1'b0;
      limit_on_q  <= 1'b0;
    end else begin
      skip_left_q <= skip_left_d;
      budget_q    <= budget_d;
      finished_q  <= finished_d;
      limit_on_q  <= limit_on_d;
    end
  end

endmodule

@@ design/olrw_skid.sv @@
// Result register with a skid stage between the window core and the output channel.
// Input ready comes from a register, so the core never waits on the output ready.
// Depends on olrw_pkg.
module olrw_skid import olrw_pkg::*; #(
  parameter int unsigned DATA_W = 50
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              ready_o,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o,
  input  logic              ready_i
);

  logic              out_valid_q, skid_valid_q;
  logic [DATA_W-1:0] out_data_q, skid_data_q;
  logic              pop;

  assign pop     = out_valid_q && ready_i;
  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_data_q;

  // Advance the output register, park a transfer in the skid stage when stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_data_q <= skid_data_q;
      end else if (push_i) begin
        out_data_q <= data_i;
      end
    end else if (push_i) begin
      skid_data_q <= data_i;
    end
  end

endmodule
